// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo pulse ramp package
// Shared types, constants and helpers for the servo pulse generator.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int TICKS_PER_MS = 1000;
  localparam int SUB_W        = $clog2(TICKS_PER_MS + 1);

  localparam logic [7:0]  ANGLE_FULL     = 8'd180;
  localparam logic [15:0] RESET_MIN_US   = 16'd500;
  localparam logic [15:0] RESET_MAX_US   = 16'd2400;
  localparam logic [15:0] RESET_FRAME_US = 16'd20000;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ANGLE = 3'd3;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  localparam int DIV_N_W   = 24;
  localparam int DIV_D_W   = 16;
  localparam int DIV_Q_W   = 8;
  localparam int DIV_CNT_W = 4;

  // The width mapping divides by 180 as a quarter divided by 45, through a
  // reciprocal that is exact for every product below 2**24.
  localparam int          WRECIP_SH = 31;
  localparam logic [25:0] WRECIP    = 26'd47721859;

  typedef struct packed {
    logic        kind;
    logic [15:0] move_time_ms;
    logic [7:0]  target_angle;
  } in_item_t;

  typedef struct packed {
    logic        pulse_level;
    logic [7:0]  current_angle;
    logic        moving;
    logic [15:0] pulse_width_us;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic ramp_div_start;
    logic ramp_stop;
    logic ramp_take;
    logic wmul;
    logic wscale;
    logic wtake;
    logic finish;
  } spr_cmd_t;

  typedef struct packed {
    logic ramp_go;
    logic div_done;
    logic out_free;
  } spr_sts_t;

  function automatic logic [7:0] sat_angle(input logic [7:0] a);
    return (a > ANGLE_FULL) ? ANGLE_FULL : a;
  endfunction

endpackage

// ===== rtl/servo_pulse_with_timed_ramp_core.sv =====
// ----------------------------------------------------------------------------
// Servo pulse generator with timed ramp
// Hobby-servo pulse generator that ramps linearly to a commanded angle.
// ----------------------------------------------------------------------------
// Each input request is either a one-microsecond tick or a move command that
// carries a target angle and a ramp time in milliseconds. Every request gives
// exactly one result: line level, current angle, ramp status and pulse width.
// Requests enter on in_valid/in_stall and results leave on out_valid/
// out_stall; a request is taken at a clock edge with valid high and stall low.
// One request is worked on at a time. After acceptance it passes through the
// multiply, check, width multiply, width scale and width take states to the
// result register; when a ramp is in progress, the ramp offset first goes
// through a one-bit-per-cycle divider of 8 steps before the quotient is
// taken. The width mapping uses a reciprocal multiply. The next request is
// taken in the cycle after the result is loaded. If the receiver stalls, the
// finished result is held; a second finished result waits in the controller
// until the first is taken. Registers are written through cfg_we, cfg_idx
// and cfg_wdata by the user only while idle; the block itself does not
// enforce this. Unknown indices are ignored. Synchronous reset restores the
// default configuration, holds the angle at zero and clears all counters.
// ----------------------------------------------------------------------------
module servo_pulse_with_timed_ramp_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  spr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spr_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [spr_pkg::CFG_W-1:0]      cfg_wdata
);
  import spr_pkg::*;

  spr_cmd_t cmd;
  spr_sts_t sts;

  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  spr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/spr_div.sv =====
// ----------------------------------------------------------------------------
// Servo pulse ramp divider
// Restoring divider, one quotient bit per cycle, for quotients that fit in
// eight bits.
// ----------------------------------------------------------------------------
module spr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [spr_pkg::DIV_N_W-1:0]  dividend,
  input  logic [spr_pkg::DIV_D_W-1:0]  divisor,
  output logic [spr_pkg::DIV_Q_W-1:0]  quotient,
  output logic                         done
);
  import spr_pkg::*;

  localparam int SH_W = DIV_D_W + DIV_Q_W - 1;

  logic [DIV_N_W-1:0]   rem_r;
  logic [SH_W-1:0]      dsh_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_N_W-1:0]   dsh_ext;
  logic                 fits;

  assign dsh_ext  = {{(DIV_N_W-SH_W){1'b0}}, dsh_r};
  assign fits     = rem_r >= dsh_ext;
  assign quotient = q_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend;
        dsh_r  <= {divisor, {(DIV_Q_W-1){1'b0}}};
        q_r    <= '0;
        cnt_r  <= DIV_CNT_W'(DIV_Q_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - dsh_ext;
        end
        q_r   <= {q_r[DIV_Q_W-2:0], fits};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/spr_dp.sv =====
// ----------------------------------------------------------------------------
// Servo pulse ramp datapath
// Configuration, ramp and frame state, angle and width arithmetic, result
// register.
// ----------------------------------------------------------------------------
module spr_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spr_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [spr_pkg::CFG_W-1:0]      cfg_wdata,
  input  spr_pkg::spr_cmd_t              cmd,
  output spr_pkg::spr_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spr_pkg::out_item_t             out_data
);
  import spr_pkg::*;

  logic [15:0]        min_r, max_r, period_r;
  logic [15:0]        frame_r;
  logic [SUB_W-1:0]   sub_r;
  logic [15:0]        elapsed_r;
  logic [7:0]         start_r, goal_r, span_r, angle_r;
  logic [15:0]        rtime_r;
  logic               up_r, active_r, line_r, kind_r;
  logic [23:0]        prod_r, lim_r;
  logic signed [25:0] wprod_r;
  logic [15:0]        wq_r;
  logic [15:0]        width_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [SUB_W-1:0]   sub_nxt;
  logic [7:0]         tgt;
  logic signed [16:0] diff;
  logic [25:0]        wmag;
  logic [47:0]        wsc;
  logic [16:0]        frame_nxt;
  logic               line_nxt;
  logic [DIV_Q_W-1:0] q;
  logic               div_done;

  assign sub_nxt   = sub_r + 1'b1;
  assign tgt       = sat_angle(in_data.target_angle);
  assign diff      = $signed({1'b0, max_r}) - $signed({1'b0, min_r});
  assign wmag      = wprod_r[25] ? 26'(-wprod_r) : 26'(wprod_r);
  assign wsc       = {26'd0, wmag[23:2]} * {22'd0, WRECIP};
  assign frame_nxt = {1'b0, frame_r} + 17'd1;
  assign line_nxt  = (kind_r == KIND_TICK) ? (frame_r < width_r) : line_r;

  spr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.ramp_div_start),
    .dividend (prod_r),
    .divisor  (rtime_r),
    .quotient (q),
    .done     (div_done)
  );

  assign sts.ramp_go  = active_r && (rtime_r != 16'd0) && (prod_r < lim_r);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= RESET_MIN_US;
      max_r       <= RESET_MAX_US;
      period_r    <= RESET_FRAME_US;
      frame_r     <= 16'd0;
      sub_r       <= '0;
      elapsed_r   <= 16'd0;
      start_r     <= 8'd0;
      goal_r      <= 8'd0;
      span_r      <= 8'd0;
      rtime_r     <= 16'd0;
      up_r        <= 1'b0;
      active_r    <= 1'b0;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIN_PULSE:  min_r    <= cfg_wdata;
          CFG_MAX_PULSE:  max_r    <= cfg_wdata;
          CFG_FRAME:      period_r <= cfg_wdata;
          CFG_INIT_ANGLE: begin
            start_r  <= sat_angle(cfg_wdata[7:0]);
            goal_r   <= sat_angle(cfg_wdata[7:0]);
            active_r <= 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd.load) begin
        kind_r <= in_data.kind;
        if (in_data.kind == KIND_MOVE) begin
          rtime_r   <= in_data.move_time_ms;
          start_r   <= goal_r;
          up_r      <= tgt > goal_r;
          span_r    <= (tgt > goal_r) ? tgt - goal_r : goal_r - tgt;
          goal_r    <= tgt;
          elapsed_r <= 16'd0;
          sub_r     <= '0;
          active_r  <= 1'b1;
        end else if (sub_nxt >= SUB_W'(TICKS_PER_MS)) begin
          sub_r <= '0;
          if (elapsed_r != 16'hFFFF) begin
            elapsed_r <= elapsed_r + 16'd1;
          end
        end else begin
          sub_r <= sub_nxt;
        end
      end

      if (cmd.mul) begin
        prod_r <= {8'd0, elapsed_r} * {16'd0, span_r};
        lim_r  <= {16'd0, span_r} * {8'd0, rtime_r};
      end

      if (cmd.ramp_stop) begin
        active_r <= 1'b0;
        start_r  <= goal_r;
        angle_r  <= goal_r;
      end

      if (cmd.ramp_take) begin
        angle_r <= up_r ? start_r + q : start_r - q;
      end

      if (cmd.wmul) begin
        wprod_r <= 26'($signed({1'b0, angle_r})) * 26'(diff);
      end

      if (cmd.wscale) begin
        wq_r <= wsc[WRECIP_SH+15:WRECIP_SH];
      end

      if (cmd.wtake) begin
        width_r <= wprod_r[25] ? min_r - wq_r : min_r + wq_r;
      end

      if (cmd.finish) begin
        out_valid_r          <= 1'b1;
        out_r.pulse_level    <= line_nxt;
        out_r.current_angle  <= angle_r;
        out_r.moving         <= active_r;
        out_r.pulse_width_us <= width_r;
        if (kind_r == KIND_TICK) begin
          line_r  <= line_nxt;
          frame_r <= (frame_nxt >= {1'b0, period_r}) ? 16'd0 : frame_nxt[15:0];
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/spr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Servo pulse ramp controller
// Sequences one request through ramp evaluation, width mapping and output.
// ----------------------------------------------------------------------------
module spr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output spr_pkg::spr_cmd_t  cmd,
  input  spr_pkg::spr_sts_t  sts
);
  import spr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DIVA  = 3'd3;
  localparam logic [2:0] S_WMUL  = 3'd4;
  localparam logic [2:0] S_WSCL  = 3'd5;
  localparam logic [2:0] S_WTAKE = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.ramp_go) begin
          cmd.ramp_div_start = 1'b1;
          state_nxt          = S_DIVA;
        end else begin
          cmd.ramp_stop = 1'b1;
          state_nxt     = S_WMUL;
        end
      end
      S_DIVA: begin
        if (sts.div_done) begin
          cmd.ramp_take = 1'b1;
          state_nxt     = S_WMUL;
        end
      end
      S_WMUL: begin
        cmd.wmul  = 1'b1;
        state_nxt = S_WSCL;
      end
      S_WSCL: begin
        cmd.wscale = 1'b1;
        state_nxt  = S_WTAKE;
      end
      S_WTAKE: begin
        cmd.wtake = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_MUL)
    else $error("accepted request did not start evaluation");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIVA)
    else $error("divider finished while no division was awaited");

  a_finish_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_one_step_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ramp_div_start |-> !cmd.wscale)
    else $error("ramp division and width scaling issued together");

endmodule

// ===== tb/servo_pulse_with_timed_ramp_core_tb.sv =====
// ----------------------------------------------------------------------------
// Servo pulse ramp core testbench
// Drives ticks and move commands into the servo pulse generator and compares
// every result with a local model of the ramp, the angle-to-width mapping and
// the frame counter. A directed table comes first, then random traffic with
// short tick runs during slow ramps, under several register settings and
// three idling profiles.
// ----------------------------------------------------------------------------
module servo_pulse_with_timed_ramp_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spr_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_ROWS    = 20;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{'{KIND_TICK, 16'h0000, 8'd0},   1'b1, '{1'b1, 8'd0,   1'b0, 16'd500}},
    '{'{KIND_MOVE, 16'h0000, 8'd180}, 1'b1, '{1'b1, 8'd180, 1'b0, 16'd2400}},
    '{'{KIND_TICK, 16'h0000, 8'd0},   1'b1, '{1'b1, 8'd180, 1'b0, 16'd2400}},
    '{'{KIND_MOVE, 16'h0000, 8'd255}, 1'b1, '{1'b1, 8'd180, 1'b0, 16'd2400}},
    '{'{KIND_MOVE, 16'h0000, 8'd0},   1'b1, '{1'b1, 8'd0,   1'b0, 16'd500}},
    '{'{KIND_MOVE, 16'hFFFF, 8'd180}, 1'b1, '{1'b1, 8'd0,   1'b1, 16'd500}},
    '{'{KIND_TICK, 16'hFFFF, 8'hFF},  1'b0, '0},
    '{'{KIND_MOVE, 16'h0001, 8'd90},  1'b0, '0},
    '{'{KIND_TICK, 16'h0000, 8'd0},   1'b0, '0},
    '{'{KIND_MOVE, 16'hFFFF, 8'd181}, 1'b0, '0},
    '{'{KIND_MOVE, 16'h0005, 8'd200}, 1'b1, '{1'b1, 8'd180, 1'b0, 16'd2400}},
    '{'{KIND_MOVE, 16'h8000, 8'h80},  1'b0, '0},
    '{'{KIND_TICK, 16'h1234, 8'h56},  1'b0, '0},
    '{'{KIND_MOVE, 16'h00FF, 8'h7F},  1'b0, '0},
    '{'{KIND_TICK, 16'h0000, 8'd0},   1'b0, '0},
    '{'{KIND_MOVE, 16'h5555, 8'hAA},  1'b0, '0},
    '{'{KIND_MOVE, 16'hAAAA, 8'h55},  1'b0, '0},
    '{'{KIND_TICK, 16'hFFFF, 8'hFF},  1'b0, '0},
    '{'{KIND_MOVE, 16'h0000, 8'd181}, 1'b1, '{1'b1, 8'd180, 1'b0, 16'd2400}},
    '{'{KIND_TICK, 16'h0000, 8'd0},   1'b0, '0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  servo_pulse_with_timed_ramp_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Local copy of the servo registers and ramp state.
  logic [15:0] reg_min, reg_max, reg_frame;
  logic [7:0]  reg_init;
  logic [15:0] m_frame_cnt, m_elapsed, m_ramp_time;
  logic [9:0]  m_sub_ms;
  logic [7:0]  m_start, m_goal, m_span;
  logic        m_up, m_active, m_line;

  out_item_t servo_out_q[$];
  int        mismatch_count;
  int        snd_idle;
  int        rcv_idle;
  int        hold_reqs;
  int        hold_done;
  int        hold_left;

  function automatic logic [7:0] clamp_angle(input logic [7:0] a);
    return (a > 8'd180) ? 8'd180 : a;
  endfunction

  function automatic void servo_reset();
    reg_min     = 16'd500;
    reg_max     = 16'd2400;
    reg_frame   = 16'd20000;
    reg_init    = 8'd0;
    m_frame_cnt = '0;
    m_sub_ms    = '0;
    m_elapsed   = '0;
    m_start     = 8'd0;
    m_goal      = 8'd0;
    m_span      = '0;
    m_ramp_time = '0;
    m_up        = 1'b0;
    m_active    = 1'b0;
    m_line      = 1'b0;
  endfunction

  function automatic void servo_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      CFG_MIN_PULSE: reg_min = val;
      CFG_MAX_PULSE: reg_max = val;
      CFG_FRAME: reg_frame = val;
      CFG_INIT_ANGLE: begin
        reg_init = clamp_angle(val[7:0]);
        m_start  = reg_init;
        m_goal   = reg_init;
        m_active = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [7:0] ramp_angle();
    int unsigned off;
    if (m_active) begin
      if (m_ramp_time != 16'd0) begin
        off = (32'(m_elapsed) * 32'(m_span)) / 32'(m_ramp_time);
        if (off < 32'(m_span))
          return m_up ? m_start + 8'(off) : m_start - 8'(off);
      end
      m_active = 1'b0;
      m_start  = m_goal;
    end
    return m_goal;
  endfunction

  function automatic logic [15:0] width_of(input logic [7:0] a);
    longint lo, diff, w;
    lo   = longint'(reg_min);
    diff = longint'(reg_max) - lo;
    w    = lo + (longint'(a) * diff) / 180;
    return w[15:0];
  endfunction

  function automatic out_item_t step_servo(input in_item_t req);
    out_item_t   r;
    logic [7:0]  tgt, ang;
    logic [15:0] w;
    if (req.kind == KIND_MOVE) begin
      tgt         = clamp_angle(req.target_angle);
      m_ramp_time = req.move_time_ms;
      m_start     = m_goal;
      m_up        = tgt > m_goal;
      m_span      = m_up ? tgt - m_goal : m_goal - tgt;
      m_goal      = tgt;
      m_elapsed   = '0;
      m_sub_ms    = '0;
      m_active    = 1'b1;
      ang         = ramp_angle();
      w           = width_of(ang);
    end else begin
      m_sub_ms = m_sub_ms + 10'd1;
      if (m_sub_ms >= TICKS_PER_MS) begin
        m_sub_ms = '0;
        if (m_elapsed != 16'hFFFF)
          m_elapsed = m_elapsed + 16'd1;
      end
      ang         = ramp_angle();
      w           = width_of(ang);
      m_line      = m_frame_cnt < w;
      m_frame_cnt = m_frame_cnt + 16'd1;
      if (m_frame_cnt >= reg_frame)
        m_frame_cnt = '0;
    end
    r.pulse_level    = m_line;
    r.current_angle  = ang;
    r.moving         = m_active;
    r.pulse_width_us = w;
    return r;
  endfunction

  function automatic in_item_t mk_req(input logic kind, input logic [15:0] t,
                                      input logic [7:0] a);
    in_item_t r;
    r.kind         = kind;
    r.move_time_ms = t;
    r.target_angle = a;
    return r;
  endfunction

  function automatic in_item_t rand_req();
    logic [15:0] t;
    logic [7:0]  a;
    int          pick;
    if ($urandom_range(99) >= 20)
      return mk_req(KIND_TICK, 16'($urandom), 8'($urandom));
    pick = $urandom_range(9);
    if (pick < 4)
      t = 16'd0;
    else if (pick < 8)
      t = 16'($urandom_range(3, 1));
    else
      t = 16'($urandom);
    a = ($urandom_range(9) < 7) ? 8'($urandom_range(180)) : 8'($urandom);
    return mk_req(KIND_MOVE, t, a);
  endfunction

  task automatic send_req(input in_item_t req);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    servo_out_q.push_back(step_servo(req));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (servo_out_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    servo_cfg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_setting(input int k);
    wait_drained();
    case (k)
      0: begin
        cfg_write(CFG_MIN_PULSE, 16'd3);
        cfg_write(CFG_MAX_PULSE, 16'd30);
        cfg_write(CFG_FRAME, 16'd25);
        cfg_write(CFG_INIT_ANGLE, 16'hA55A);
        cfg_write(3'd4, 16'h1234);
        cfg_write(3'd7, 16'hFFFF);
      end
      1: begin
        cfg_write(CFG_MIN_PULSE, 16'd2400);
        cfg_write(CFG_MAX_PULSE, 16'd500);
        cfg_write(CFG_FRAME, 16'd0);
        cfg_write(CFG_INIT_ANGLE, 16'h00FF);
      end
      2: begin
        cfg_write(CFG_MIN_PULSE, 16'hFFFF);
        cfg_write(CFG_MAX_PULSE, 16'h0000);
        cfg_write(CFG_FRAME, 16'd1);
        cfg_write(CFG_INIT_ANGLE, 16'h00B4);
      end
      3: begin
        cfg_write(CFG_MIN_PULSE, 16'h0000);
        cfg_write(CFG_MAX_PULSE, 16'hFFFF);
        cfg_write(CFG_FRAME, 16'hFFFF);
        cfg_write(CFG_INIT_ANGLE, 16'h0000);
      end
      4: begin
        cfg_write(CFG_MIN_PULSE, 16'd10);
        cfg_write(CFG_MAX_PULSE, 16'd2);
        cfg_write(CFG_FRAME, 16'd7);
        cfg_write(CFG_INIT_ANGLE, 16'hFF00);
      end
      default: begin
        cfg_write(CFG_MIN_PULSE, 16'd500);
        cfg_write(CFG_MAX_PULSE, 16'd2400);
        cfg_write(CFG_FRAME, 16'd40);
        cfg_write(CFG_INIT_ANGLE, 16'd45);
        cfg_write(3'd5, 16'hAAAA);
        cfg_write(3'd6, 16'h5555);
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic random_reqs(input int n);
    repeat (n) send_req(rand_req());
  endtask

  // A slow ramp that is re-targeted part way through.
  task automatic ramp_watch();
    send_req(mk_req(KIND_MOVE, 16'd2, 8'($urandom_range(180))));
    repeat ($urandom_range(30, 10))
      send_req(mk_req(KIND_TICK, 16'($urandom), 8'($urandom)));
    send_req(mk_req(KIND_MOVE, 16'd1, 8'($urandom)));
    repeat ($urandom_range(30, 10))
      send_req(mk_req(KIND_TICK, 16'($urandom), 8'($urandom)));
  endtask

  task automatic run_phase(input int snd, input int rcv, input int set_a, input int set_b);
    snd_idle = snd;
    rcv_idle = rcv;
    apply_setting(set_a);
    hold_reqs = hold_reqs + 1;
    random_reqs(60);
    wait_drained();
    apply_setting(set_b);
    ramp_watch();
    random_reqs(60);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_done = hold_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (servo_out_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data);
        mismatch_count = mismatch_count + 1;
      end else if (out_data !== servo_out_q[0]) begin
        $display("%0t: expected level %0d angle %0d moving %0d width %0d, got %0d %0d %0d %0d",
                 $realtime, servo_out_q[0].pulse_level, servo_out_q[0].current_angle,
                 servo_out_q[0].moving, servo_out_q[0].pulse_width_us, out_data.pulse_level,
                 out_data.current_angle, out_data.moving, out_data.pulse_width_us);
        mismatch_count = mismatch_count + 1;
        void'(servo_out_q.pop_front());
      end else begin
        void'(servo_out_q.pop_front());
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet = quiet + 1;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    snd_idle       = 0;
    rcv_idle       = 0;
    hold_reqs      = 0;
    hold_done      = 0;
    hold_left      = 0;
    servo_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_req(DIR_TAB[i].req);
      if (DIR_TAB[i].typed)
        servo_out_q[$] = DIR_TAB[i].want;
    end
    run_phase(19, 67, 0, 1);
    run_phase(67, 19, 2, 3);
    run_phase(0, 0, 4, 5);
    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && servo_out_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
